/* hw/rtl/pdvm_pkg.sv */
`default_nettype none
package pdvm_pkg;

  // Fixed-point format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int DIV_W     = WORD_W + FRAC_BITS;   // dividend and quotient width
  localparam int REM_W     = WORD_W - 1;           // divisor is a positive 31-bit value
  localparam int NDC_LOG   = 40;                   // clamp bound of ndc before raster map
  localparam int NDC_W     = NDC_LOG + 2;          // clamped ndc plus or minus one
  localparam int EXT_W     = (DIV_W + 1 > NDC_W) ? DIV_W + 1 : NDC_W;
  localparam int SIZE_W    = 13;
  localparam int PROD_W    = NDC_W + SIZE_W + 1;
  localparam int LANES     = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

  // Divider lane indexes
  localparam int L_X = 0;
  localparam int L_Y = 1;
  localparam int L_Z = 2;
  localparam int L_W = 3;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] nq;   // dividend bits shift out at the top, quotient bits in below
  } div_lane_t;

  typedef struct packed {
    logic                  bad;
    logic [2:0]            neg;      // signs of x, y, z
    logic [REM_W-1:0]      divisor;
    div_lane_t [LANES-1:0] lane;
  } div_stage_t;

  typedef struct packed {
    logic [WORD_W-1:0] raster_x;
    logic [WORD_W-1:0] raster_y;
    logic [WORD_W-1:0] depth_ndc;
    logic [WORD_W-1:0] inverse_w;
    logic              bad_w;
    logic              saturated;
  } result_t;

  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
    mag32 = v[WORD_W-1] ? WORD_W'(-v) : v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/pdvm_in_if.sv */
`default_nettype none
interface pdvm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] clip_x;
  logic [31:0] clip_y;
  logic [31:0] clip_z;
  logic [31:0] clip_w;
  modport source (output valid, clip_x, clip_y, clip_z, clip_w, input ready);
  modport sink   (input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pdvm_out_if.sv */
`default_nettype none
interface pdvm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] raster_x;
  logic [31:0] raster_y;
  logic [31:0] depth_ndc;
  logic [31:0] inverse_w;
  logic        bad_w;
  logic        saturated;
  modport source (output valid, raster_x, raster_y, depth_ndc, inverse_w, bad_w, saturated,
                  input ready);
  modport sink   (input valid, raster_x, raster_y, depth_ndc, inverse_w, bad_w, saturated,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/pdvm_div_cell.sv */
`default_nettype none
module pdvm_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  pdvm_pkg::div_stage_t stage_i,
  output logic                 valid_o,
  output pdvm_pkg::div_stage_t stage_o
);
  import pdvm_pkg::*;

  div_stage_t       stage_d;
  logic [REM_W:0]   trial [LANES];
  logic [REM_W:0]   diff  [LANES];
  logic [LANES-1:0] ge;

  // One restoring step per lane: shift in a dividend bit, subtract if it fits
  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < LANES; l++) begin
      trial[l] = {stage_i.lane[l].rem, stage_i.lane[l].nq[DIV_W-1]};
      diff[l]  = trial[l] - {1'b0, stage_i.divisor};
      ge[l]    = trial[l] >= {1'b0, stage_i.divisor};
      stage_d.lane[l].rem = ge[l] ? diff[l][REM_W-1:0] : trial[l][REM_W-1:0];
      stage_d.lane[l].nq  = {stage_i.lane[l].nq[DIV_W-2:0], ge[l]};
    end
  end

  // Advance with the whole pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_o <= stage_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pdvm_post.sv */
`default_nettype none
module pdvm_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  pdvm_pkg::div_stage_t        stage_i,
  input  logic [pdvm_pkg::SIZE_W-1:0] width_i,
  input  logic [pdvm_pkg::SIZE_W-1:0] height_i,
  output logic                        valid_o,
  output pdvm_pkg::result_t           res_o
);
  import pdvm_pkg::*;

  localparam logic signed [EXT_W-1:0] NDC_MAX = EXT_W'(1) <<< NDC_LOG;
  localparam logic signed [EXT_W-1:0] NDC_MIN = -NDC_MAX;
  localparam logic signed [EXT_W-1:0] S32_MAX = EXT_W'(32'h7fff_ffff);
  localparam logic signed [EXT_W-1:0] S32_MIN = -S32_MAX - EXT_W'(1);
  localparam logic signed [PROD_W-1:0] P32_MAX = PROD_W'(32'h7fff_ffff);
  localparam logic signed [PROD_W-1:0] P32_MIN = -P32_MAX - PROD_W'(1);
  localparam logic signed [NDC_W-1:0] ONE = NDC_W'(1) <<< FRAC_BITS;

  logic signed [EXT_W-1:0] nx, ny, nz, cx, cy;
  logic                    sat_z, sat_w;

  logic                     va_q, vb_q;
  logic signed [NDC_W-1:0]  ax_q, ay_q;
  logic [WORD_W-1:0]        dz_q, iw_q, dz_b_q, iw_b_q;
  logic                     sat_q, bad_q, sat_b_q, bad_b_q;
  logic signed [PROD_W-1:0] px_q, py_q;

  logic signed [PROD_W-1:0] hx, hy;
  logic                     sat_x, sat_y;
  result_t                  res_d;

  // Stage A: apply signs, clamp ndc, saturate depth and 1/w
  always_comb begin
    nx = EXT_W'({1'b0, stage_i.lane[L_X].nq});
    ny = EXT_W'({1'b0, stage_i.lane[L_Y].nq});
    nz = EXT_W'({1'b0, stage_i.lane[L_Z].nq});
    if (stage_i.neg[0]) nx = -nx;
    if (stage_i.neg[1]) ny = -ny;
    if (stage_i.neg[2]) nz = -nz;
    cx = (nx > NDC_MAX) ? NDC_MAX : ((nx < NDC_MIN) ? NDC_MIN : nx);
    cy = (ny > NDC_MAX) ? NDC_MAX : ((ny < NDC_MIN) ? NDC_MIN : ny);
    sat_z = (nz > S32_MAX) || (nz < S32_MIN);
    sat_w = EXT_W'({1'b0, stage_i.lane[L_W].nq}) > S32_MAX;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ax_q  <= cx[NDC_W-1:0] + ONE;
      ay_q  <= ONE - cy[NDC_W-1:0];
      dz_q  <= sat_z ? (nz[EXT_W-1] ? 32'h8000_0000 : 32'h7fff_ffff) : nz[WORD_W-1:0];
      iw_q  <= sat_w ? 32'h7fff_ffff : stage_i.lane[L_W].nq[WORD_W-1:0];
      sat_q <= sat_z | sat_w;
      bad_q <= stage_i.bad;
    end
  end

  // Stage B: scale by the image size
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q    <= PROD_W'(ax_q) * PROD_W'($signed({1'b0, width_i}));
      py_q    <= PROD_W'(ay_q) * PROD_W'($signed({1'b0, height_i}));
      dz_b_q  <= dz_q;
      iw_b_q  <= iw_q;
      sat_b_q <= sat_q;
      bad_b_q <= bad_q;
    end
  end

  // Stage C: halve toward zero, saturate, zero everything on a bad w
  always_comb begin
    hx    = $signed(px_q + PROD_W'(px_q[PROD_W-1])) >>> 1;
    hy    = $signed(py_q + PROD_W'(py_q[PROD_W-1])) >>> 1;
    sat_x = (hx > P32_MAX) || (hx < P32_MIN);
    sat_y = (hy > P32_MAX) || (hy < P32_MIN);
    res_d.raster_x  = sat_x ? (hx[PROD_W-1] ? 32'h8000_0000 : 32'h7fff_ffff)
                            : hx[WORD_W-1:0];
    res_d.raster_y  = sat_y ? (hy[PROD_W-1] ? 32'h8000_0000 : 32'h7fff_ffff)
                            : hy[WORD_W-1:0];
    res_d.depth_ndc = dz_b_q;
    res_d.inverse_w = iw_b_q;
    res_d.bad_w     = 1'b0;
    res_d.saturated = sat_b_q | sat_x | sat_y;
    if (bad_b_q) begin
      res_d       = '0;
      res_d.bad_w = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      valid_o <= vb_q;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/perspective_divide_viewport_map.sv */
`default_nettype none
// Channel   Dir  Role   Payload
// in_req    in   sink   clip_x, clip_y, clip_z, clip_w (Q16.16)
// out_res   out  source raster_x, raster_y, depth_ndc, inverse_w, bad_w, saturated
// cfg_*     in   write  index 0 image_width, index 1 image_height
//
// One request per cycle unless the output stalls; 48 divider cells, 3 post stages.
// The divider chain retires one quotient bit per cell for all four lanes.
// A stalled output holds the whole pipeline; in_req.ready follows out_res.ready
// whenever the output register is full.
// Reset clears the valid bits and loads the image size defaults 640 by 480.
module perspective_divide_viewport_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pdvm_in_if.sink                        in_req,
  pdvm_out_if.source                     out_res,
  input  logic                           cfg_we_i,
  input  logic [pdvm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pdvm_pkg::SIZE_W-1:0]    cfg_data_i
);
  import pdvm_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  logic              adv;
  div_stage_t        stage [DIV_W+1];
  logic              valid [DIV_W+1];
  logic [WORD_W-1:0] mx, my, mz;
  result_t           res;
  logic              out_valid;

  // Hold the image size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance whenever the output register is free or being drained
  assign adv          = !out_valid || out_res.ready;
  assign in_req.ready = adv;

  // Build the divider request from magnitudes
  always_comb begin
    mx = mag32(in_req.clip_x);
    my = mag32(in_req.clip_y);
    mz = mag32(in_req.clip_z);
    valid[0]          = in_req.valid;
    stage[0].bad      = in_req.clip_w[WORD_W-1] || (in_req.clip_w == '0);
    stage[0].neg      = {in_req.clip_z[WORD_W-1], in_req.clip_y[WORD_W-1],
                         in_req.clip_x[WORD_W-1]};
    stage[0].divisor  = stage[0].bad ? REM_W'(1) : in_req.clip_w[REM_W-1:0];
    stage[0].lane[L_X] = '{rem: '0, nq: DIV_W'(mx) << FRAC_BITS};
    stage[0].lane[L_Y] = '{rem: '0, nq: DIV_W'(my) << FRAC_BITS};
    stage[0].lane[L_Z] = '{rem: '0, nq: DIV_W'(mz) << FRAC_BITS};
    stage[0].lane[L_W] = '{rem: '0, nq: DIV_W'(1) << (2 * FRAC_BITS)};
  end

  // Row of divider cells, one quotient bit each
  for (genvar c = 0; c < DIV_W; c++) begin : g_cell
    pdvm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid[c]),
      .stage_i (stage[c]),
      .valid_o (valid[c+1]),
      .stage_o (stage[c+1])
    );
  end

  pdvm_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (valid[DIV_W]),
    .stage_i  (stage[DIV_W]),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (out_valid),
    .res_o    (res)
  );

  assign out_res.valid     = out_valid;
  assign out_res.raster_x  = res.raster_x;
  assign out_res.raster_y  = res.raster_y;
  assign out_res.depth_ndc = res.depth_ndc;
  assign out_res.inverse_w = res.inverse_w;
  assign out_res.bad_w     = res.bad_w;
  assign out_res.saturated = res.saturated;

  // A bad w gives an all-zero result
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && res.bad_w |-> res.raster_x == '0 && res.raster_y == '0 &&
      res.depth_ndc == '0 && res.inverse_w == '0 && !res.saturated)
    else $error("bad w result not zero");

  // 1/w of a positive w is never negative
  a_iw_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !res.bad_w |-> !res.inverse_w[WORD_W-1])
    else $error("negative inverse w");

  // A stalled result holds while the pipeline is frozen
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_res.ready |=> out_valid && $stable(res))
    else $error("stalled result changed");

endmodule
`default_nettype wire

/* dv/perspective_divide_viewport_map_checker.sv */
module perspective_divide_viewport_map_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pdvm_in_if   in_mon,
  pdvm_out_if  out_mon,
  input  logic                           cfg_we_i,
  input  logic [pdvm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pdvm_pkg::SIZE_W-1:0]    cfg_data_i,
  output int   fail_count_o,
  output int   pending_o
);
  import pdvm_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  result_t           vertex_q[$];

  // Saturate a wide value to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint clamp_ndc(input longint v);
    longint lim;
    lim = longint'(1) << NDC_LOG;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Divide x, y, z by w and map to raster space
  function automatic result_t project_vertex(input logic [31:0] cx, cy, cz, cw,
                                             input logic [SIZE_W-1:0] wd, ht);
    result_t r;
    longint  one, x, y, z, w, nx, ny, nz, iw, rx, ry;
    bit      sat;
    one = longint'(1) << FRAC_BITS;
    x = longint'($signed(cx));
    y = longint'($signed(cy));
    z = longint'($signed(cz));
    w = longint'($signed(cw));
    r = '0;
    sat = 1'b0;
    if (w <= 0) begin
      r.bad_w = 1'b1;
      return r;
    end
    nx = (x * one) / w;
    ny = (y * one) / w;
    nz = (z * one) / w;
    iw = (one * one) / w;
    rx = ((clamp_ndc(nx) + one) * longint'(wd)) / 2;
    ry = ((one - clamp_ndc(ny)) * longint'(ht)) / 2;
    r.raster_x  = clamp32(rx, sat);
    r.raster_y  = clamp32(ry, sat);
    r.depth_ndc = clamp32(nz, sat);
    r.inverse_w = clamp32(iw, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v, inout int fails);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  assign pending_o = vertex_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    int      fails;
    if (!rst_ni) begin
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      fail_count_o <= 0;
      vertex_q.delete();
    end else begin
      fails = fail_count_o;
      // Track register writes
      if (cfg_we_i && cfg_idx_i == CFG_WIDTH) width_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_HEIGHT) height_q <= cfg_data_i;
      // Predict each accepted request
      if (in_mon.valid && in_mon.ready)
        vertex_q.push_back(project_vertex(in_mon.clip_x, in_mon.clip_y, in_mon.clip_z,
                                          in_mon.clip_w, width_q, height_q));
      // Compare each accepted result
      if (out_mon.valid && out_mon.ready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time,
                   out_mon.raster_x);
          fails++;
        end else begin
          exp_r = vertex_q.pop_front();
          compare_field("raster_x", exp_r.raster_x, out_mon.raster_x, fails);
          compare_field("raster_y", exp_r.raster_y, out_mon.raster_y, fails);
          compare_field("depth_ndc", exp_r.depth_ndc, out_mon.depth_ndc, fails);
          compare_field("inverse_w", exp_r.inverse_w, out_mon.inverse_w, fails);
          compare_field("bad_w", 32'(exp_r.bad_w), 32'(out_mon.bad_w), fails);
          compare_field("saturated", 32'(exp_r.saturated), 32'(out_mon.saturated), fails);
        end
      end
      fail_count_o <= fails;
    end
  end
endmodule

/* dv/perspective_divide_viewport_map_tb.sv */
module perspective_divide_viewport_map_tb;
  import pdvm_pkg::*;

  localparam int LATENCY     = DIV_W + 3;
  localparam int STALL_LIMIT = 2000;
  // Index past the register list, written to check that it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0]    cfg_data_i;
  int   fail_count, pending;
  int   idle_cycles;
  bit   quiet_tail;

  pdvm_in_if  in_req();
  pdvm_out_if out_res();

  perspective_divide_viewport_map dut (
    .clk_i, .rst_ni, .in_req(in_req.sink), .out_res(out_res.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  perspective_divide_viewport_map_checker checker_i (
    .clk_i, .rst_ni, .in_mon(in_req), .out_mon(out_res),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: count cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure in random bursts
  initial begin
    int n;
    out_res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 11);
      out_res.ready <= quiet_tail || $urandom_range(0, 2) != 0;
      repeat (n) @(posedge clk_i);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic [31:0] rand_w();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'($urandom_range(1, 16));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'($urandom_range(0, 1) ? 0 : -1);
      default: return 32'($urandom_range(1 << 12, 1 << 20));
    endcase
  endfunction

  task automatic send_vertex(input logic [31:0] x, y, z, w);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_req.valid  <= 1'b1;
    in_req.clip_x <= x;
    in_req.clip_y <= y;
    in_req.clip_z <= z;
    in_req.clip_w <= w;
    do @(posedge clk_i); while (!in_req.ready);
  endtask

  task automatic drain();
    int guard;
    in_req.valid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] widths[6];
    logic [SIZE_W-1:0] heights[6];
    quiet_tail   = 1'b0;
    idle_cycles  = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_WIDTH;
    cfg_data_i   = '0;
    in_req.valid = 1'b0;
    in_req.clip_x = '0;
    in_req.clip_y = '0;
    in_req.clip_z = '0;
    in_req.clip_w = '0;
    widths  = '{13'd640, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd1920};
    heights = '{13'd480, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd1080};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of every field, bad w, saturation
    send_vertex(32'h0, 32'h0, 32'h0, 32'h10000);
    send_vertex(32'h10000, 32'hffff0000, 32'h8000, 32'h10000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h1);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_vertex(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_vertex(32'h12345678, 32'h1, 32'h2, 32'h0);
    send_vertex(32'h1, 32'h2, 32'h3, 32'hffffffff);
    send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h80000000);
    send_vertex(32'h10000, 32'h10000, 32'h10000, 32'h100);
    send_vertex(32'hfffeffff, 32'h1, 32'hffffffff, 32'h2);
    send_vertex(32'h5555aaaa, 32'haaaa5555, 32'h0ff00ff0, 32'h00010001);
    drain();

    // Random phases across size settings, extremes included
    for (int p = 0; p < 6; p++) begin
      write_size(CFG_WIDTH, widths[p]);
      write_size(CFG_HEIGHT, heights[p]);
      write_size(CFG_UNUSED, SIZE_W'($urandom()));
      if (p == 5) quiet_tail = 1'b1;
      for (int i = 0; i < 200; i++) send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_w());
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
